>>> src/nlct_pkg.sv
// shared types and constants for the nand lun and channel timing core
`timescale 1ns / 1ps
`default_nettype none

package nlct_pkg;

	localparam int NUM_CHANNELS     = 8;
	localparam int LUNS_PER_CHANNEL = 8;
	localparam int NUM_LUNS         = NUM_CHANNELS * LUNS_PER_CHANNEL;
	localparam int LUN_IDX_W        = (NUM_LUNS > 1) ? $clog2(NUM_LUNS) : 1;

	localparam int TIME_W = 48;
	localparam int LAT_W  = 26;
	localparam int OP_W   = 2;
	localparam int CH_W   = 3;
	localparam int LN_W   = 3;
	localparam int IDX_W  = 2;

	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 48;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	typedef enum logic [OP_W-1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_ERASE = 2'd2
	} op_t;

	typedef enum logic [IDX_W-1:0] {
		REG_READ_LAT  = 2'd0,
		REG_PROG_LAT  = 2'd1,
		REG_ERASE_LAT = 2'd2,
		REG_XFER_LAT  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [LAT_W-1:0] read_lat;
		logic [LAT_W-1:0] prog_lat;
		logic [LAT_W-1:0] erase_lat;
		logic [LAT_W-1:0] xfer_lat;
	} cfg_t;

	typedef struct packed {
		logic              cmd_ok;
		op_t               op;
		logic [TIME_W-1:0] start;
		logic [TIME_W-1:0] lun_free;
		logic [TIME_W-1:0] ch_free;
	} calc_in_t;

	typedef struct packed {
		logic              lun_we;
		logic              ch_we;
		logic [TIME_W-1:0] lun_next;
		logic [TIME_W-1:0] ch_next;
		logic [TIME_W-1:0] latency;
	} calc_out_t;

	function automatic logic [TIME_W-1:0] sat_add(
		input logic [TIME_W-1:0] t,
		input logic [LAT_W-1:0]  d
	);
		logic [TIME_W:0] s;
		s = {1'b0, t} + {{(TIME_W+1-LAT_W){1'b0}}, d};
		return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
	endfunction

	function automatic logic [TIME_W-1:0] later(
		input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b
	);
		return (a > b) ? a : b;
	endfunction

endpackage

`default_nettype wire

>>> src/nand_lun_channel_timing_core.sv
// top level of the nand lun and channel timing core
//
//   group    dir  tdata fields (low bit up)                         tuser/tlast
//   s_axis   in   operation[1:0] channel[4:2] lun[7:5] start[55:8]  none
//   m_axis   out  latency_ns[47:0]                                  none
//   cfg      in   cfg_we, cfg_idx (register index), cfg_wdata      none
//
// one command per cycle: input word -> s1 (lun table read) -> result register
// lun free times live in a 64 x 48 table with a registered read port and a
// write-to-read bypass; per-entry valid bits make unwritten entries read zero
// reset clears the valid bits, channel free times and loads the default latencies
// no clearing pass: the core accepts words from the first cycle after reset
// an unread result stalls s1, which in turn drops s_axis_tready
`timescale 1ns / 1ps
`default_nettype none

module nand_lun_channel_timing_core
	import nlct_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  s_axis_tvalid,
	output      logic                  s_axis_tready,
	// operation, channel, lun, start_time_ns
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,

	output      logic                  m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// latency_ns
	output      logic [OUT_DATA_W-1:0] m_axis_tdata,

	input  wire logic                  cfg_we,
	input  wire logic [IDX_W-1:0]      cfg_idx,
	input  wire logic [LAT_W-1:0]      cfg_wdata
);

	cfg_t cfg_q;

	// input decode
	logic [CH_W-1:0]      in_ch;
	logic [LN_W-1:0]      in_ln;
	logic                 in_ok;
	logic [LUN_IDX_W-1:0] in_idx;
	logic                 in_acc;

	// stage 1
	logic                 vld_s1;
	logic                 ok_s1;
	op_t                  op_s1;
	logic [CH_W-1:0]      ch_s1;
	logic [LUN_IDX_W-1:0] idx_s1;
	logic [TIME_W-1:0]    start_s1;
	logic [TIME_W-1:0]    lun_rd_s1;
	logic                 adv_s1;

	// state
	logic [TIME_W-1:0]    lun_mem [NUM_LUNS];
	logic [NUM_LUNS-1:0]  lun_vld_q;
	logic [TIME_W-1:0]    ch_free_q [NUM_CHANNELS];

	logic                 out_vld_q;
	logic [TIME_W-1:0]    out_lat_q;

	calc_in_t             ci;
	calc_out_t            co;
	logic                 byp;

	assign in_ch  = s_axis_tdata[OP_W +: CH_W];
	assign in_ln  = s_axis_tdata[OP_W+CH_W +: LN_W];
	assign in_ok  = (int'(in_ch) < NUM_CHANNELS) && (int'(in_ln) < LUNS_PER_CHANNEL);
	assign in_idx = LUN_IDX_W'(int'(in_ch) * LUNS_PER_CHANNEL + int'(in_ln));

	assign adv_s1        = vld_s1 && (!out_vld_q || m_axis_tready);
	assign s_axis_tready = !vld_s1 || adv_s1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.read_lat  <= LAT_W'(40000);
			cfg_q.prog_lat  <= LAT_W'(200000);
			cfg_q.erase_lat <= LAT_W'(2000000);
			cfg_q.xfer_lat  <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_READ_LAT:  cfg_q.read_lat  <= cfg_wdata;
				REG_PROG_LAT:  cfg_q.prog_lat  <= cfg_wdata;
				REG_ERASE_LAT: cfg_q.erase_lat <= cfg_wdata;
				REG_XFER_LAT:  cfg_q.xfer_lat  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	// same entry written by the word leaving s1 this edge
	assign byp = adv_s1 && co.lun_we && (idx_s1 == in_idx);

	// stage 1 payload and lun table read
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ok_s1    <= in_ok;
			op_s1    <= op_t'(s_axis_tdata[OP_W-1:0]);
			ch_s1    <= in_ch;
			idx_s1   <= in_idx;
			start_s1 <= s_axis_tdata[OP_W+CH_W+LN_W +: TIME_W];
			if (byp) begin
				lun_rd_s1 <= co.lun_next;
			end else if (lun_vld_q[in_idx]) begin
				lun_rd_s1 <= lun_mem[in_idx];
			end else begin
				lun_rd_s1 <= '0;
			end
		end
	end

	always_comb begin
		ci.cmd_ok   = ok_s1;
		ci.op       = op_s1;
		ci.start    = start_s1;
		ci.lun_free = lun_rd_s1;
		ci.ch_free  = ch_free_q[ch_s1];
	end

	nlct_calc u_calc (
		.cfg (cfg_q),
		.ci  (ci),
		.co  (co)
	);

	// lun table write
	always_ff @(posedge clk) begin
		if (adv_s1 && co.lun_we) begin
			lun_mem[idx_s1] <= co.lun_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lun_vld_q <= '0;
		end else if (adv_s1 && co.lun_we) begin
			lun_vld_q[idx_s1] <= 1'b1;
		end
	end

	// channel free times
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				ch_free_q[i] <= '0;
			end
		end else if (adv_s1 && co.ch_we) begin
			ch_free_q[ch_s1] <= co.ch_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_lat_q <= co.latency;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_lat_q;

	// valid bits only ever get set
	a_vld_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(($past(lun_vld_q) & ~lun_vld_q) == '0))
		else $error("lun valid bit cleared");

	// rejected commands leave the channel state alone
	a_bad_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !co.lun_we) |=> (ch_free_q[$past(ch_s1)] == $past(ch_free_q[ch_s1])))
		else $error("channel state changed by rejected command");

	// no transfer time means no channel update
	a_no_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && cfg_q.xfer_lat == '0) |-> !co.ch_we)
		else $error("channel written with transfer disabled");

	// a result shows up only after a word leaves s1
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(adv_s1))
		else $error("result without a command");

	// s1 never gets overwritten while it holds a stalled word
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv_s1) |=> (vld_s1 && $stable(start_s1) && $stable(idx_s1)))
		else $error("stalled s1 word lost");

endmodule

`default_nettype wire

>>> src/nlct_calc.sv
// finish time arithmetic for one command: lun busy time, channel transfer, latency
`timescale 1ns / 1ps
`default_nettype none

module nlct_calc
	import nlct_pkg::*;
(
	input  cfg_t      cfg,
	input  calc_in_t  ci,
	output calc_out_t co
);

	logic [TIME_W-1:0] lun_begin;
	logic [TIME_W-1:0] lun_done;
	logic [LAT_W-1:0]  op_lat;
	logic [TIME_W-1:0] rd_xfer;
	logic [TIME_W-1:0] wr_xfer;
	logic [TIME_W-1:0] wr_done;
	logic [TIME_W-1:0] finish;
	logic              valid_op;
	logic              xfer_on;

	always_comb begin
		valid_op = 1'b1;
		op_lat   = cfg.read_lat;
		unique case (ci.op)
			OP_READ:  op_lat = cfg.read_lat;
			OP_WRITE: op_lat = cfg.prog_lat;
			OP_ERASE: op_lat = cfg.erase_lat;
			default:  valid_op = 1'b0;
		endcase
	end

	assign xfer_on   = (cfg.xfer_lat != '0);
	assign lun_begin = later(ci.lun_free, ci.start);
	assign lun_done  = sat_add(lun_begin, op_lat);

	// read moves data after the lun, write moves data before the program
	assign rd_xfer = sat_add(later(ci.ch_free, lun_done), cfg.xfer_lat);
	assign wr_xfer = sat_add(later(ci.ch_free, ci.start), cfg.xfer_lat);
	assign wr_done = sat_add(later(lun_done, wr_xfer), cfg.prog_lat);

	always_comb begin
		co.lun_we   = ci.cmd_ok && valid_op;
		co.ch_we    = 1'b0;
		co.lun_next = lun_done;
		co.ch_next  = rd_xfer;
		finish      = lun_done;
		if (xfer_on && ci.op == OP_READ) begin
			co.ch_we = co.lun_we;
			finish   = rd_xfer;
		end else if (xfer_on && ci.op == OP_WRITE) begin
			co.ch_we    = co.lun_we;
			co.ch_next  = wr_xfer;
			co.lun_next = wr_done;
			finish      = wr_done;
		end
		co.latency = co.lun_we ? (finish - ci.start) : '0;
	end

endmodule

`default_nettype wire

>>> tb/tb_nand_lun_channel_timing_core.sv
// self-checking testbench for the nand lun and channel timing core
`timescale 1ns / 1ps

module tb_nand_lun_channel_timing_core
	import nlct_pkg::*;
();

	localparam logic [OP_W-1:0]  OP_UNUSED = 2'd3;
	localparam logic [LAT_W-1:0] LAT_MAX   = '1;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	// operation[1:0], channel[4:2], lun[7:5], start_time_ns[55:8]
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	// latency_ns[47:0]
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we;
	logic [IDX_W-1:0]      cfg_idx;
	logic [LAT_W-1:0]      cfg_wdata;

	// predicted state of the core
	logic [TIME_W-1:0] lun_ready [NUM_LUNS];
	logic [TIME_W-1:0] chan_ready [NUM_CHANNELS];
	logic [LAT_W-1:0]  read_lat, prog_lat, erase_lat, xfer_lat;

	logic [TIME_W-1:0] pending_latency [$];
	int                error_count = 0;
	int                word_count = 0;
	int                gap_odds = 0;
	int                stall_odds = 0;
	int                stall_left = 0;

	nand_lun_channel_timing_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb_nand_lun_channel_timing_core: done, errors");
		$finish;
	end

	function automatic logic [TIME_W-1:0] capped_sum(input logic [TIME_W-1:0] t,
			input logic [LAT_W-1:0] d);
		logic [63:0] s;
		s = 64'(t) + 64'(d);
		return (s > 64'(TIME_MAX)) ? TIME_MAX : s[TIME_W-1:0];
	endfunction

	function automatic logic [TIME_W-1:0] max_time(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		return (a >= b) ? a : b;
	endfunction

	// advances the predicted lun and channel free times, returns the latency
	function automatic logic [TIME_W-1:0] issue_command(input logic [OP_W-1:0] op,
			input logic [CH_W-1:0] ch, input logic [LN_W-1:0] ln,
			input logic [TIME_W-1:0] start);
		int unsigned       slot;
		logic [TIME_W-1:0] lun_done, bus_done, done;
		if (op == OP_UNUSED)
			return '0;
		slot = ch * LUNS_PER_CHANNEL + ln;
		case (op)
			OP_READ:  lun_done = capped_sum(max_time(lun_ready[slot], start), read_lat);
			OP_WRITE: lun_done = capped_sum(max_time(lun_ready[slot], start), prog_lat);
			default:  lun_done = capped_sum(max_time(lun_ready[slot], start), erase_lat);
		endcase
		done = lun_done;
		if (xfer_lat != '0 && op != OP_ERASE) begin
			if (op == OP_READ) begin
				bus_done = capped_sum(max_time(chan_ready[ch], lun_done), xfer_lat);
				done = bus_done;
			end else begin
				// write: channel first, then the program time is charged again
				bus_done = capped_sum(max_time(chan_ready[ch], start), xfer_lat);
				lun_done = capped_sum(max_time(lun_done, bus_done), prog_lat);
				done = lun_done;
			end
			chan_ready[ch] = bus_done;
		end
		lun_ready[slot] = lun_done;
		return done - start;
	endfunction

	function automatic logic [LAT_W-1:0] random_latency();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return LAT_MAX;
			2, 3:    return LAT_W'($urandom_range(1, 200));
			default: return LAT_W'($urandom_range(1, 50000));
		endcase
	endfunction

	task automatic report_error(input string what);
		$display("ERROR at %0t ns: %s", $time, what);
		error_count++;
	endtask

	task automatic set_latency(input reg_idx_t idx, input logic [LAT_W-1:0] value);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_wdata = value;
		case (idx)
			REG_READ_LAT:  read_lat = value;
			REG_PROG_LAT:  prog_lat = value;
			REG_ERASE_LAT: erase_lat = value;
			default:       xfer_lat = value;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send_command(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
			input logic [LN_W-1:0] ln, input logic [TIME_W-1:0] start);
		if (gap_odds > 0 && $urandom_range(0, 99) < gap_odds) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {start, ln, ch, op};
		do @(posedge clk); while (!s_axis_tready);
		pending_latency.insert(pending_latency.size(), issue_command(op, ch, ln, start));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_axis_tvalid = 1'b0;
		while (pending_latency.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		logic [TIME_W-1:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_latency.size() == 0) begin
				report_error($sformatf("word %0d: latency %0d with none pending",
					word_count, m_axis_tdata));
			end else begin
				want = pending_latency[0];
				pending_latency.delete(0);
				if (m_axis_tdata !== want)
					report_error($sformatf("word %0d: latency %0d, expected %0d",
						word_count, m_axis_tdata, want));
			end
			word_count++;
		end
	end

	// downstream stall bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready = 1'b0;
			stall_left--;
		end else if (stall_odds > 0 && $urandom_range(0, 99) < stall_odds) begin
			m_axis_tready = 1'b0;
			stall_left = $urandom_range(0, 5);
		end else begin
			m_axis_tready = 1'b1;
		end
	end

	task automatic test_reset_defaults();
		send_command(OP_READ, 0, 0, '0);
		send_command(OP_WRITE, 0, 0, '0);
		send_command(OP_ERASE, 7, 7, 48'd100);
		send_command(OP_UNUSED, 3, 3, TIME_MAX);
		send_command(OP_READ, 7, 7, '0);
		send_command(OP_READ, 5, 2, 48'h0000_1234_5678);
	endtask

	task automatic test_time_saturation();
		send_command(OP_READ, 1, 1, TIME_MAX);
		send_command(OP_WRITE, 2, 2, TIME_MAX - 48'd5);
		send_command(OP_ERASE, 2, 2, '0);
		send_command(OP_READ, 4, 6, TIME_MAX - 48'd39999);
	endtask

	task automatic test_latency_extremes();
		wait_idle();
		set_latency(REG_READ_LAT, LAT_MAX);
		set_latency(REG_PROG_LAT, LAT_MAX);
		set_latency(REG_ERASE_LAT, LAT_MAX);
		set_latency(REG_XFER_LAT, LAT_MAX);
		send_command(OP_READ, 6, 0, 48'hAAAA_AAAA_AAAA);
		send_command(OP_WRITE, 6, 1, 48'h5555_5555_5555);
		send_command(OP_ERASE, 6, 2, 48'd7);
		wait_idle();
		set_latency(REG_READ_LAT, '0);
		set_latency(REG_PROG_LAT, '0);
		set_latency(REG_ERASE_LAT, '0);
		set_latency(REG_XFER_LAT, '0);
		send_command(OP_READ, 6, 4, '0);
		send_command(OP_WRITE, 6, 3, 48'd1);
	endtask

	task automatic test_channel_path();
		wait_idle();
		set_latency(REG_READ_LAT, 26'd100);
		set_latency(REG_PROG_LAT, 26'd300);
		set_latency(REG_ERASE_LAT, 26'd700);
		set_latency(REG_XFER_LAT, 26'd50);
		send_command(OP_READ, 3, 0, 48'd1000);
		send_command(OP_READ, 3, 1, 48'd1000);
		send_command(OP_WRITE, 3, 0, 48'd1000);
		send_command(OP_WRITE, 3, 2, 48'd1010);
		send_command(OP_READ, 3, 2, 48'd1020);
		send_command(OP_ERASE, 3, 3, 48'd1020);
		send_command(OP_WRITE, 7, 7, TIME_MAX - 48'd10);
	endtask

	task automatic test_random_traffic(input int phases, input int per_phase);
		logic [TIME_W-1:0] now_ns, start;
		logic [OP_W-1:0]   op;
		logic [CH_W-1:0]   ch;
		logic [LN_W-1:0]   ln;
		int                pick;
		now_ns = 48'd5000;
		for (int p = 0; p < phases; p++) begin
			wait_idle();
			if (p == phases - 1) begin
				gap_odds = 0;
				stall_odds = 0;
				stall_left = 0;
			end else begin
				pick = $urandom_range(0, 2);
				gap_odds = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
				pick = $urandom_range(0, 2);
				stall_odds = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
			end
			set_latency(REG_READ_LAT, random_latency());
			set_latency(REG_PROG_LAT, random_latency());
			set_latency(REG_ERASE_LAT, random_latency());
			set_latency(REG_XFER_LAT, ($urandom_range(0, 3) == 0) ? '0 : random_latency());
			for (int i = 0; i < per_phase; i++) begin
				now_ns += $urandom_range(0, 2000);
				ch = ($urandom_range(0, 3) == 0) ? CH_W'($urandom_range(0, 7))
					: CH_W'($urandom_range(0, 1));
				ln = ($urandom_range(0, 3) == 0) ? LN_W'($urandom_range(0, 7))
					: LN_W'($urandom_range(0, 1));
				op = ($urandom_range(0, 15) == 0) ? OP_UNUSED : OP_W'($urandom_range(0, 2));
				pick = $urandom_range(0, 49);
				if (pick == 0) begin
					// jump the issue clock somewhere across the lower half of the range
					now_ns = {1'b0, 15'($urandom_range(0, 32'h7FFF)), $urandom()};
					start = now_ns;
				end else if (pick == 1) begin
					ch = 7;
					ln = 7;
					start = TIME_MAX - $urandom_range(0, 100000);
				end else begin
					start = now_ns;
				end
				send_command(op, ch, ln, start);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		read_lat = 26'd40000;
		prog_lat = 26'd200000;
		erase_lat = 26'd2000000;
		xfer_lat = '0;
		foreach (lun_ready[i])
			lun_ready[i] = '0;
		foreach (chan_ready[i])
			chan_ready[i] = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_time_saturation();
		test_latency_extremes();
		test_channel_path();
		test_random_traffic(6, 100);

		wait_idle();
		if (error_count == 0)
			$display("tb_nand_lun_channel_timing_core: done, clean");
		else
			$display("tb_nand_lun_channel_timing_core: done, errors");
		$finish;
	end

endmodule

>>> nand_lun_channel_timing_core.f
src/nlct_pkg.sv
src/nlct_calc.sv
src/nand_lun_channel_timing_core.sv
tb/tb_nand_lun_channel_timing_core.sv
